// ===== hw/rtl/mvab_pkg.sv =====
// ----------------------------------------------------------------------------
// mvab_pkg: shared definitions for the vertex angle-sum boundary test
// Field widths, op codes, angle constants and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package mvab_pkg;

  // Default sizes of the point store and the coordinates.
  localparam int NUM_POINTS_DEF  = 1024;
  localparam int COORD_WIDTH_DEF = 16;

  // Fixed field widths.
  localparam int IDX_W = 10;
  localparam int SUM_W = 24;
  localparam int ANG_W = 15;

  // Op codes of an input beat.
  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_TRIANGLE = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  // Angle constants.
  localparam logic [SUM_W-1:0] SUM_MAX      = 24'hFFFFFF;
  localparam logic [SUM_W-1:0] THRESH_RESET = 24'd26896;
  localparam int               PI_Q16       = 205887;
  localparam logic [ANG_W-1:0] ANG_PI_Q13   = 15'((PI_Q16 + 4) >> 3);
  localparam int               CORDIC_STEPS = 16;

  // Arctangent of 2^-i in Q.16, rounded to nearest.
  function automatic logic [15:0] atan_q16(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd51472;
      4'd1:    v = 16'd30386;
      4'd2:    v = 16'd16055;
      4'd3:    v = 16'd8150;
      4'd4:    v = 16'd4091;
      4'd5:    v = 16'd2047;
      4'd6:    v = 16'd1024;
      4'd7:    v = 16'd512;
      4'd8:    v = 16'd256;
      4'd9:    v = 16'd128;
      4'd10:   v = 16'd64;
      4'd11:   v = 16'd32;
      4'd12:   v = 16'd16;
      4'd13:   v = 16'd8;
      4'd14:   v = 16'd4;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mvab_if.sv =====
// ----------------------------------------------------------------------------
// mvab_if: channel interfaces of the vertex angle-sum boundary test
// Input item channel, result channel and threshold write channel.
// ----------------------------------------------------------------------------
`default_nettype none

// Input item channel.
interface mvab_in_if #(
  parameter int CW = mvab_pkg::COORD_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [mvab_pkg::IDX_W-1:0]  vertex_a;
  logic [mvab_pkg::IDX_W-1:0]  vertex_b;
  logic [mvab_pkg::IDX_W-1:0]  vertex_c;
  logic signed [CW-1:0]        coord_x;
  logic signed [CW-1:0]        coord_y;
  logic signed [CW-1:0]        coord_z;

  modport source (output valid, op, vertex_a, vertex_b, vertex_c,
                  coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, op, vertex_a, vertex_b, vertex_c,
                  coord_x, coord_y, coord_z, output ready);
endinterface

// Query result channel.
interface mvab_out_if;
  logic                        valid;
  logic                        ready;
  logic [mvab_pkg::IDX_W-1:0]  queried_vertex;
  logic [mvab_pkg::SUM_W-1:0]  angle_total;
  logic                        on_boundary;

  modport source (output valid, queried_vertex, angle_total, on_boundary,
                  input ready);
  modport sink   (input valid, queried_vertex, angle_total, on_boundary,
                  output ready);
endinterface

// Threshold register write channel.
interface mvab_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mvab_pkg::SUM_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mvab_corner.sv =====
// ----------------------------------------------------------------------------
// mvab_corner: iterative corner angle unit
// Computes the angle at corner o between edges o->p and o->q in Q.13,
// using one shared multiplier, shift loops, a bit-pair square root and a
// 16-step CORDIC vectoring run.
// ----------------------------------------------------------------------------
`default_nettype none

module mvab_corner #(
  parameter int CW = mvab_pkg::COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [3*CW-1:0]             o_pt,
  input  logic [3*CW-1:0]             p_pt,
  input  logic [3*CW-1:0]             q_pt,
  output logic                        done,
  output logic [mvab_pkg::ANG_W-1:0]  angle
);
  import mvab_pkg::*;

  localparam int DW   = CW + 1;  // edge component width
  localparam int SCL  = 17;      // scaled edge magnitude bound, bits
  localparam int CLB  = 30;      // cross/dot magnitude bound, bits
  localparam int MULW = 30;      // shared multiplier operand width
  localparam int ACW  = 38;      // cross/dot accumulator width
  localparam int MAGW = 37;      // cross/dot magnitude width
  localparam int XW   = 40;      // CORDIC x/y width
  localparam int ZW   = 21;      // CORDIC angle width

  typedef enum logic [10:0] {
    C_IDLE   = 11'b00000000001,
    C_DIFF   = 11'b00000000010,
    C_SCALE  = 11'b00000000100,
    C_MUL    = 11'b00000001000,
    C_CMAG   = 11'b00000010000,
    C_CSHIFT = 11'b00000100000,
    C_SQ     = 11'b00001000000,
    C_SQRT   = 11'b00010000000,
    C_CSET   = 11'b00100000000,
    C_CORDIC = 11'b01000000000,
    C_FIN    = 11'b10000000000
  } cstate_t;

  // One product of the cross/dot schedule.
  typedef struct packed {
    logic [1:0] ui;
    logic [1:0] wi;
    logic [1:0] tgt;
    logic       sub;
  } mterm_t;

  cstate_t                  state_r, state_nxt;
  logic [DW-1:0]            um_r [3];
  logic [DW-1:0]            wm_r [3];
  logic [2:0]               us_r, ws_r;
  logic signed [ACW-1:0]    acc_r [4];
  logic [MAGW-1:0]          cm_r [4];
  logic                     dneg_r;
  logic [2*MULW-1:0]        prod_r;
  logic                     pneg_r, pval_r;
  logic [1:0]               ptgt_r;
  logic [63:0]              sq_r, rt_r;
  logic [4:0]               st_r;
  logic signed [XW-1:0]     x_r, y_r;
  logic signed [ZW-1:0]     z_r;
  logic [ANG_W-1:0]         angle_r;
  logic                     done_r;

  logic signed [DW-1:0]     du_w [3];
  logic signed [DW-1:0]     dw_w [3];
  logic                     ubig_w, wbig_w, cbig_w, uz_w, wz_w;
  mterm_t                   mt_w;
  logic [MULW-1:0]          ma_w, mb_w;
  logic signed [ACW-1:0]    term_w;
  logic [63:0]              bit_w, rb_w;
  logic signed [XW-1:0]     xs_w, ys_w;
  logic signed [ZW-1:0]     at_w, zf_w, zc_w;

  // Product schedule: three cross components, then the dot product.
  function automatic mterm_t sched(input logic [3:0] k);
    mterm_t t;
    case (k)
      4'd0:    t = '{ui: 2'd1, wi: 2'd2, tgt: 2'd0, sub: 1'b0};
      4'd1:    t = '{ui: 2'd2, wi: 2'd1, tgt: 2'd0, sub: 1'b1};
      4'd2:    t = '{ui: 2'd2, wi: 2'd0, tgt: 2'd1, sub: 1'b0};
      4'd3:    t = '{ui: 2'd0, wi: 2'd2, tgt: 2'd1, sub: 1'b1};
      4'd4:    t = '{ui: 2'd0, wi: 2'd1, tgt: 2'd2, sub: 1'b0};
      4'd5:    t = '{ui: 2'd1, wi: 2'd0, tgt: 2'd2, sub: 1'b1};
      4'd6:    t = '{ui: 2'd0, wi: 2'd0, tgt: 2'd3, sub: 1'b0};
      4'd7:    t = '{ui: 2'd1, wi: 2'd1, tgt: 2'd3, sub: 1'b0};
      default: t = '{ui: 2'd2, wi: 2'd2, tgt: 2'd3, sub: 1'b0};
    endcase
    return t;
  endfunction

  // Edge vectors from the three corner points.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      du_w[i] = $signed({p_pt[i*CW+CW-1], p_pt[i*CW +: CW]})
              - $signed({o_pt[i*CW+CW-1], o_pt[i*CW +: CW]});
      dw_w[i] = $signed({q_pt[i*CW+CW-1], q_pt[i*CW +: CW]})
              - $signed({o_pt[i*CW+CW-1], o_pt[i*CW +: CW]});
    end
  end

  // Range and zero tests for the shift loops.
  always_comb begin
    ubig_w = 1'b0;
    wbig_w = 1'b0;
    cbig_w = 1'b0;
    uz_w   = 1'b1;
    wz_w   = 1'b1;
    for (int i = 0; i < 3; i++) begin
      ubig_w = ubig_w | (|(um_r[i] >> SCL));
      wbig_w = wbig_w | (|(wm_r[i] >> SCL));
      uz_w   = uz_w & ~(|um_r[i]);
      wz_w   = wz_w & ~(|wm_r[i]);
    end
    for (int i = 0; i < 4; i++) begin
      cbig_w = cbig_w | (|(cm_r[i] >> CLB));
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mt_w = sched(st_r[3:0]);
    if (state_r == C_SQ) begin
      ma_w = MULW'(cm_r[st_r[1:0]]);
      mb_w = MULW'(cm_r[st_r[1:0]]);
    end else begin
      ma_w = MULW'(um_r[mt_w.ui]);
      mb_w = MULW'(wm_r[mt_w.wi]);
    end
    term_w = pneg_r ? -$signed(ACW'(prod_r)) : $signed(ACW'(prod_r));
  end

  // Square root step and CORDIC step terms.
  always_comb begin
    bit_w = 64'd1 << {st_r, 1'b0};
    rb_w  = rt_r + bit_w;
    xs_w  = x_r >>> st_r[3:0];
    ys_w  = y_r >>> st_r[3:0];
    at_w  = $signed(ZW'(atan_q16(st_r[3:0])));
    zf_w  = dneg_r ? (ZW'(PI_Q16) - z_r) : z_r;
    if (zf_w < 0) begin
      zc_w = '0;
    end else if (zf_w > $signed(ZW'(PI_Q16))) begin
      zc_w = ZW'(PI_Q16);
    end else begin
      zc_w = zf_w;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE:   if (start) state_nxt = C_DIFF;
      C_DIFF:   state_nxt = (uz_w || wz_w) ? C_IDLE : C_SCALE;
      C_SCALE:  if (!ubig_w && !wbig_w) state_nxt = C_MUL;
      C_MUL:    if (st_r == 5'd9) state_nxt = C_CMAG;
      C_CMAG:   state_nxt = C_CSHIFT;
      C_CSHIFT: if (!cbig_w) state_nxt = C_SQ;
      C_SQ:     if (st_r == 5'd3) state_nxt = C_SQRT;
      C_SQRT:   if (st_r == 5'd0) state_nxt = C_CSET;
      C_CSET:   state_nxt = (rt_r == 64'd0) ? C_IDLE : C_CORDIC;
      C_CORDIC: if (st_r == 5'(CORDIC_STEPS - 1)) state_nxt = C_FIN;
      C_FIN:    state_nxt = C_IDLE;
      default:  state_nxt = C_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= ((state_r == C_DIFF) && (uz_w || wz_w)) ||
                 ((state_r == C_CSET) && (rt_r == 64'd0)) ||
                 (state_r == C_FIN);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= ma_w * mb_w;
    case (state_r)
      C_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          us_r[i] <= du_w[i][DW-1];
          ws_r[i] <= dw_w[i][DW-1];
          um_r[i] <= du_w[i][DW-1] ? DW'(-du_w[i]) : DW'(du_w[i]);
          wm_r[i] <= dw_w[i][DW-1] ? DW'(-dw_w[i]) : DW'(dw_w[i]);
        end
      end
      C_DIFF: begin
        for (int i = 0; i < 4; i++) acc_r[i] <= '0;
        angle_r <= '0;
        st_r    <= '0;
        pval_r  <= 1'b0;
      end
      C_SCALE: begin
        // Each vector shifts on its own until its magnitudes fit 17 bits.
        for (int i = 0; i < 3; i++) begin
          if (ubig_w) um_r[i] <= um_r[i] >> 1;
          if (wbig_w) wm_r[i] <= wm_r[i] >> 1;
        end
      end
      C_MUL: begin
        pval_r <= (st_r < 5'd9);
        pneg_r <= us_r[mt_w.ui] ^ ws_r[mt_w.wi] ^ mt_w.sub;
        ptgt_r <= mt_w.tgt;
        if (pval_r) acc_r[ptgt_r] <= acc_r[ptgt_r] + term_w;
        st_r <= st_r + 5'd1;
      end
      C_CMAG: begin
        for (int i = 0; i < 4; i++) begin
          cm_r[i] <= acc_r[i][ACW-1] ? MAGW'(-acc_r[i]) : MAGW'(acc_r[i]);
        end
        dneg_r <= acc_r[3][ACW-1];
      end
      C_CSHIFT: begin
        // Shared shift of cross and dot magnitudes down to 30 bits.
        for (int i = 0; i < 4; i++) begin
          if (cbig_w) cm_r[i] <= cm_r[i] >> 1;
        end
        st_r   <= '0;
        sq_r   <= '0;
        pval_r <= 1'b0;
      end
      C_SQ: begin
        pval_r <= (st_r < 5'd3);
        if (pval_r) sq_r <= sq_r + 64'(prod_r);
        if (st_r == 5'd3) begin
          st_r <= 5'd31;
          rt_r <= '0;
        end else begin
          st_r <= st_r + 5'd1;
        end
      end
      C_SQRT: begin
        if (sq_r >= rb_w) begin
          sq_r <= sq_r - rb_w;
          rt_r <= (rt_r >> 1) + bit_w;
        end else begin
          rt_r <= rt_r >> 1;
        end
        st_r <= st_r - 5'd1;
      end
      C_CSET: begin
        angle_r <= dneg_r ? ANG_PI_Q13 : '0;
        x_r     <= $signed(XW'(cm_r[3]));
        y_r     <= $signed(XW'(rt_r));
        z_r     <= '0;
        st_r    <= '0;
      end
      C_CORDIC: begin
        if (y_r > 0) begin
          x_r <= x_r + ys_w;
          y_r <= y_r - xs_w;
          z_r <= z_r + at_w;
        end else begin
          x_r <= x_r - ys_w;
          y_r <= y_r + xs_w;
          z_r <= z_r - at_w;
        end
        st_r <= st_r + 5'd1;
      end
      C_FIN: begin
        angle_r <= ANG_W'((zc_w + ZW'(4)) >>> 3);
      end
      default: ;
    endcase
  end

  assign done  = done_r;
  assign angle = angle_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mesh_vertex_angle_boundary_test_core.sv =====
// ----------------------------------------------------------------------------
// mesh_vertex_angle_boundary_test_core: vertex angle-sum boundary test
// Point store, per-vertex corner angle sums and boundary queries.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries one item per beat: op 0 writes a point and clears its
//   sum, op 1 adds the three corner angles of a triangle, op 2 queries a
//   vertex. Indices at or above NUM_POINTS are ignored (a query returns 0).
//   out_bus returns one beat per query: index, saturated sum and boundary
//   flag (sum below the threshold). cfg_bus writes the threshold at any
//   beat; it is always ready.
//   A query waits for the output register to be free. A triangle is
//   accepted and its three points are fetched, then the three corners run
//   in turn on the one corner unit. A corner ends early for a zero-length
//   edge and skips the CORDIC for parallel edges; otherwise it runs the
//   multiplier schedule, shift loops, 32-step square root and 16-step CORDIC.
//   in_bus.ready is low meanwhile. After reset the angle sums are cleared
//   one entry a cycle, with in_bus.ready low. When the receiver stalls,
//   the result waits in the output register; a further query waits until
//   it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_vertex_angle_boundary_test_core #(
  parameter int NUM_POINTS  = mvab_pkg::NUM_POINTS_DEF,
  parameter int COORD_WIDTH = mvab_pkg::COORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mvab_in_if.sink      in_bus,
  mvab_out_if.source   out_bus,
  mvab_cfg_if.sink     cfg_bus
);
  import mvab_pkg::*;

  localparam int PAW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int PW  = 3 * COORD_WIDTH;

  typedef enum logic [6:0] {
    T_CLEAR  = 7'b0000001,
    T_IDLE   = 7'b0000010,
    T_QRD    = 7'b0000100,
    T_PRD    = 7'b0001000,
    T_CSTART = 7'b0010000,
    T_CWAIT  = 7'b0100000,
    T_ACRD   = 7'b1000000
  } tstate_t;

  tstate_t           state_r, state_nxt;
  logic [PAW-1:0]    clr_r;
  logic [IDX_W-1:0]  vidx_r [3];
  logic              rng_r;
  logic [1:0]        rd_r, cn_r;
  logic [PW-1:0]     pt_r [3];
  logic [SUM_W-1:0]  thresh_r;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_vtx_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic              out_bnd_r;

  // Memories.
  logic [PW-1:0]     pt_mem  [NUM_POINTS];
  logic [SUM_W-1:0]  acc_mem [NUM_POINTS];
  logic [PW-1:0]     pt_rdata_r;
  logic [SUM_W-1:0]  acc_rdata_r;

  logic              in_fire, out_free;
  logic              pt_we, acc_we;
  logic [PAW-1:0]    pt_raddr, acc_raddr, acc_waddr;
  logic [SUM_W-1:0]  acc_wdata, q_sum;
  logic [SUM_W:0]    add_w;
  logic [1:0]        c1, c2, rsel;
  logic              a_in, b_in, c_in;
  logic              c_start, c_done;
  logic [ANG_W-1:0]  c_angle;

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return int'(idx) < NUM_POINTS;
  endfunction

  function automatic logic [1:0] next3(input logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;
  assign a_in     = in_range(in_bus.vertex_a);
  assign b_in     = in_range(in_bus.vertex_b);
  assign c_in     = in_range(in_bus.vertex_c);
  assign c1       = next3(cn_r);
  assign c2       = next3(c1);
  assign rsel     = (rd_r == 2'd3) ? 2'd0 : rd_r;
  assign c_start  = (state_r == T_CSTART);

  // Corner angle unit.
  mvab_corner #(.CW(COORD_WIDTH)) u_corner (
    .clk   (clk),
    .rst_n (rst_n),
    .start (c_start),
    .o_pt  (pt_r[cn_r]),
    .p_pt  (pt_r[c1]),
    .q_pt  (pt_r[c2]),
    .done  (c_done),
    .angle (c_angle)
  );

  // Memory addresses and write controls.
  always_comb begin
    add_w     = {1'b0, acc_rdata_r} + (SUM_W + 1)'(c_angle);
    pt_raddr  = PAW'(vidx_r[rsel]);
    acc_raddr = (state_r == T_IDLE) ? PAW'(in_bus.vertex_a)
              : (state_r == T_QRD)  ? PAW'(vidx_r[0])
              : PAW'(vidx_r[cn_r]);
    pt_we     = in_fire && (in_bus.op == OP_WRITE) && a_in;
    acc_we    = 1'b0;
    acc_waddr = PAW'(in_bus.vertex_a);
    acc_wdata = '0;
    if (state_r == T_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_r;
    end else if (state_r == T_ACRD) begin
      acc_we    = 1'b1;
      acc_waddr = PAW'(vidx_r[cn_r]);
      acc_wdata = add_w[SUM_W] ? SUM_MAX : add_w[SUM_W-1:0];
    end else if (pt_we) begin
      acc_we = 1'b1;
    end
    q_sum = rng_r ? acc_rdata_r : '0;
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[PAW'(in_bus.vertex_a)] <= {in_bus.coord_z, in_bus.coord_y, in_bus.coord_x};
    end
    pt_rdata_r <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rdata_r <= acc_mem[acc_raddr];
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_CLEAR: if (clr_r == PAW'(NUM_POINTS - 1)) state_nxt = T_IDLE;
      T_IDLE: begin
        if (in_fire && (in_bus.op == OP_QUERY)) begin
          state_nxt = T_QRD;
        end else if (in_fire && (in_bus.op == OP_TRIANGLE) && a_in && b_in && c_in) begin
          state_nxt = T_PRD;
        end
      end
      T_QRD:    if (out_free) state_nxt = T_IDLE;
      T_PRD:    if (rd_r == 2'd3) state_nxt = T_CSTART;
      T_CSTART: state_nxt = T_CWAIT;
      T_CWAIT:  if (c_done) state_nxt = T_ACRD;
      T_ACRD:   state_nxt = (cn_r == 2'd2) ? T_IDLE : T_CSTART;
      default:  state_nxt = T_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_CLEAR;
      clr_r       <= '0;
      thresh_r    <= THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == T_CLEAR) clr_r <= clr_r + PAW'(1);
      if (cfg_bus.valid) thresh_r <= cfg_bus.data;
      if ((state_r == T_QRD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item registers and output payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      vidx_r[0] <= in_bus.vertex_a;
      vidx_r[1] <= in_bus.vertex_b;
      vidx_r[2] <= in_bus.vertex_c;
      rng_r     <= a_in;
      rd_r      <= '0;
      cn_r      <= '0;
    end
    if (state_r == T_PRD) begin
      if (rd_r != 2'd0) pt_r[rd_r - 2'd1] <= pt_rdata_r;
      rd_r <= rd_r + 2'd1;
    end
    if (state_r == T_ACRD) cn_r <= c1;
    if ((state_r == T_QRD) && out_free) begin
      out_vtx_r <= vidx_r[0];
      out_sum_r <= q_sum;
      out_bnd_r <= (q_sum < thresh_r);
    end
  end

  assign in_bus.ready          = (state_r == T_IDLE);
  assign cfg_bus.ready         = 1'b1;
  assign out_bus.valid         = out_valid_r;
  assign out_bus.queried_vertex = out_vtx_r;
  assign out_bus.angle_total   = out_sum_r;
  assign out_bus.on_boundary   = out_bnd_r;

endmodule

`default_nettype wire
